### design/fvsd_pkg.sv
// Shared types, constants and datapath step functions for the voltage-to-duty block.
// No dependencies; every other design file imports this package.
`default_nettype none

package fvsd_pkg;

   localparam int unsigned MID_DEPTH_DEF = 4;
   localparam int unsigned RSP_DEPTH_DEF = 2;

   localparam int unsigned SQRT_STEPS = 32;
   localparam int unsigned LDIV_STEPS = 30;
   localparam int unsigned DDIV_STEPS = 15;
   localparam int unsigned LANES      = 3;

   localparam int unsigned CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_DUTY_FLOOR   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DUTY_CEILING = 8'd1;

   localparam logic [15:0]        FULL_DUTY      = 16'd32768;
   localparam logic [15:0]        HALF_DUTY      = 16'd16384;
   localparam logic [14:0]        INV_SQRT3_Q15  = 15'd18919;
   localparam logic signed [15:0] HALF_SQRT3_Q15 = 16'sd28378;

   typedef struct packed {
      logic signed [15:0] volt_direct;
      logic signed [15:0] volt_quadrature;
      logic signed [15:0] sin_theta;
      logic signed [15:0] cos_theta;
      logic [14:0]        bus_voltage;
   } req_type;

   typedef struct packed {
      logic [15:0] duty_phase_a;
      logic [15:0] duty_phase_b;
      logic [15:0] duty_phase_c;
      logic        vector_limited;
      logic        bus_fault;
   } rsp_type;

   // front -> back hand-off
   typedef struct packed {
      logic signed [32:0] alpha;
      logic signed [32:0] beta;
      logic [29:0]        radius;
      logic [14:0]        bus;
      logic [63:0]        mag2;
      logic               limit;
      logic               fault;
   } front_item_type;

   typedef struct packed {
      logic signed [32:0] alpha;
      logic signed [32:0] beta;
      logic [29:0]        radius;
      logic [14:0]        bus;
      logic               limit;
      logic               fault;
   } side_type;

   typedef struct packed {
      logic [14:0]      bus;
      logic             limit;
      logic             fault;
      logic [LANES-1:0] neg;
      logic [LANES-1:0] big;
   } tail_type;

   typedef struct packed {
      logic [63:0] n;
      logic [34:0] rem;
      logic [31:0] root;
   } sqrt_state_type;

   typedef struct packed {
      logic [29:0] low;
      logic [31:0] rem;
      logic [29:0] quo;
   } ldiv_type;

   typedef struct packed {
      logic [14:0] low;
      logic [14:0] rem;
      logic [14:0] quo;
   } ddiv_type;

   // one root bit per call
   function automatic sqrt_state_type sqrt_step(input sqrt_state_type s);
      sqrt_state_type o;
      logic [34:0]    r;
      logic [34:0]    t;
      r   = {s.rem[32:0], s.n[63:62]};
      t   = {1'b0, s.root, 2'b01};
      o.n = {s.n[61:0], 2'b00};
      if (r >= t) begin
         o.rem  = r - t;
         o.root = {s.root[30:0], 1'b1};
      end else begin
         o.rem  = r;
         o.root = {s.root[30:0], 1'b0};
      end
      return o;
   endfunction

   // one quotient bit per call, 32-bit divisor
   function automatic ldiv_type ldiv_step(input ldiv_type s, input logic [31:0] m);
      ldiv_type    o;
      logic [32:0] t;
      t     = {s.rem, s.low[29]};
      o.low = {s.low[28:0], 1'b0};
      if (t >= {1'b0, m}) begin
         o.rem = 32'(t - {1'b0, m});
         o.quo = {s.quo[28:0], 1'b1};
      end else begin
         o.rem = t[31:0];
         o.quo = {s.quo[28:0], 1'b0};
      end
      return o;
   endfunction

   // one quotient bit per call, 15-bit divisor
   function automatic ddiv_type ddiv_step(input ddiv_type s, input logic [14:0] d);
      ddiv_type    o;
      logic [15:0] t;
      t     = {s.rem, s.low[14]};
      o.low = {s.low[13:0], 1'b0};
      if (t >= {1'b0, d}) begin
         o.rem = 15'(t - {1'b0, d});
         o.quo = {s.quo[13:0], 1'b1};
      end else begin
         o.rem = t[14:0];
         o.quo = {s.quo[13:0], 1'b0};
      end
      return o;
   endfunction

   function automatic logic [31:0] abs33(input logic signed [32:0] a);
      return a[32] ? 32'(-a) : 32'(a);
   endfunction

   function automatic logic signed [32:0] apply_sign(input logic [29:0] q, input logic neg);
      return neg ? -$signed({3'b000, q}) : $signed({3'b000, q});
   endfunction

   // saturate registers to full duty; ceiling applied last so it wins
   function automatic logic [15:0] clamp_duty(input logic [15:0] d,
                                              input logic [15:0] fl,
                                              input logic [15:0] cl);
      logic [15:0] lo;
      logic [15:0] hi;
      logic [15:0] r;
      lo = (fl > FULL_DUTY) ? FULL_DUTY : fl;
      hi = (cl > FULL_DUTY) ? FULL_DUTY : cl;
      r  = d;
      if (r < lo) r = lo;
      if (r > hi) r = hi;
      return r;
   endfunction

endpackage

`default_nettype wire

### design/fvsd_queue.sv
// Small first-in first-out register queue, used between front and back and at the output.
// Depends on fvsd_pkg for the default depth.
`default_nettype none

module fvsd_queue
   import fvsd_pkg::*;
#(
   parameter int unsigned DEPTH = MID_DEPTH_DEF,
   parameter int unsigned WIDTH = 8
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  wire  [WIDTH-1:0] wdata,
   output logic             full,
   input  wire              pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   assert property (@(posedge clock) disable iff (reset) !(full && empty))
      else $error("queue full and empty at once");

   assert property (@(posedge clock) disable iff (reset) (do_push && !do_pop) |=> !empty)
      else $error("queue empty right after a lone push");

endmodule

`default_nettype wire

### design/fvsd_front.sv
// Front pipeline: takes requests, rotates dq to alpha-beta, squares, flags limit and fault.
// Depends on fvsd_pkg.
`default_nettype none

module fvsd_front
   import fvsd_pkg::*;
(
   input  wire             clock,
   input  wire             reset,
   input  wire             in_push,
   input  req_type         in_req,
   output logic            in_full,
   input  wire             out_full,
   output logic            out_push,
   output front_item_type  out_item
);

   logic [3:0] vld_ff;
   logic       en;

   // stage 1: products
   logic signed [31:0] p_dc_ff, p_qs_ff, p_ds_ff, p_qc_ff;
   logic [29:0]        rad1_ff;
   logic [14:0]        bus1_ff;
   logic               fault1_ff;
   // stage 2: alpha/beta
   side_type           s2_ff;
   logic [31:0]        ua_ff, ub_ff;
   logic signed [32:0] alpha2, beta2;
   // stage 3: squares
   side_type           s3_ff;
   logic [63:0]        sq_a_ff, sq_b_ff;
   logic [59:0]        r2_ff;
   // stage 4: magnitude and limit decision
   front_item_type     s4_ff;
   logic [63:0]        mag2;

   assign en       = !(vld_ff[3] && out_full);
   assign in_full  = !en;
   assign out_push = vld_ff[3];
   assign out_item = s4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[2:0], in_push};
      end
   end

   assign alpha2 = 33'(p_dc_ff) - 33'(p_qs_ff);
   assign beta2  = 33'(p_ds_ff) + 33'(p_qc_ff);
   assign mag2   = sq_a_ff + sq_b_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p_dc_ff   <= in_req.volt_direct * in_req.cos_theta;
         p_qs_ff   <= in_req.volt_quadrature * in_req.sin_theta;
         p_ds_ff   <= in_req.volt_direct * in_req.sin_theta;
         p_qc_ff   <= in_req.volt_quadrature * in_req.cos_theta;
         rad1_ff   <= 30'(in_req.bus_voltage) * 30'(INV_SQRT3_Q15);
         bus1_ff   <= in_req.bus_voltage;
         fault1_ff <= (in_req.bus_voltage == '0);

         s2_ff <= '{alpha: alpha2, beta: beta2, radius: rad1_ff, bus: bus1_ff,
                    limit: 1'b0, fault: fault1_ff};
         ua_ff <= abs33(alpha2);
         ub_ff <= abs33(beta2);

         s3_ff   <= s2_ff;
         sq_a_ff <= 64'(ua_ff) * 64'(ua_ff);
         sq_b_ff <= 64'(ub_ff) * 64'(ub_ff);
         r2_ff   <= 60'(s2_ff.radius) * 60'(s2_ff.radius);

         s4_ff <= '{alpha: s3_ff.alpha, beta: s3_ff.beta, radius: s3_ff.radius,
                    bus: s3_ff.bus, mag2: mag2,
                    limit: (mag2 > {4'b0000, r2_ff}) && !s3_ff.fault,
                    fault: s3_ff.fault};
      end
   end

endmodule

`default_nettype wire

### design/fvsd_back.sv
// Back pipeline: square root, vector scaling, phase voltages, min-max offset, duty divide, clamp.
// Depends on fvsd_pkg.
`default_nettype none

module fvsd_back
   import fvsd_pkg::*;
(
   input  wire             clock,
   input  wire             reset,
   input  wire             in_empty,
   input  front_item_type  in_item,
   output logic            in_pop,
   input  wire  [15:0]     duty_floor,
   input  wire  [15:0]     duty_ceiling,
   input  wire             out_full,
   output logic            out_valid,
   output rsp_type         out_item
);

   localparam int unsigned TOTAL = SQRT_STEPS + LDIV_STEPS + DDIV_STEPS + 8;

   logic [TOTAL-1:0] vld_ff;
   logic             en;

   assign en        = !(vld_ff[TOTAL-1] && out_full);
   assign in_pop    = en && !in_empty;
   assign out_valid = vld_ff[TOTAL-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[TOTAL-2:0], !in_empty};
      end
   end

   // ---------------- square root of alpha^2 + beta^2
   side_type       side_in;
   sqrt_state_type sq_first;
   sqrt_state_type sq_ff      [SQRT_STEPS];
   side_type       sq_side_ff [SQRT_STEPS];

   assign side_in  = '{alpha: in_item.alpha, beta: in_item.beta, radius: in_item.radius,
                       bus: in_item.bus, limit: in_item.limit, fault: in_item.fault};
   assign sq_first = '{n: in_item.mag2, rem: '0, root: '0};

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff[0]      <= sqrt_step(sq_first);
         sq_side_ff[0] <= side_in;
      end
   end

   for (genvar s = 1; s < SQRT_STEPS; s++) begin : g_sqrt
      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[s]      <= sqrt_step(sq_ff[s-1]);
            sq_side_ff[s] <= sq_side_ff[s-1];
         end
      end
   end

   // ---------------- |component| * radius
   side_type    sq_last;
   side_type    p_side_ff;
   logic [61:0] pa_ff, pb_ff;
   logic [31:0] mag_ff;

   assign sq_last = sq_side_ff[SQRT_STEPS-1];

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff     <= 62'(abs33(sq_last.alpha)) * 62'(sq_last.radius);
         pb_ff     <= 62'(abs33(sq_last.beta)) * 62'(sq_last.radius);
         mag_ff    <= sq_ff[SQRT_STEPS-1].root;
         p_side_ff <= sq_last;
      end
   end

   // ---------------- divide by magnitude, both components
   ldiv_type    ld_a_ff    [LDIV_STEPS];
   ldiv_type    ld_b_ff    [LDIV_STEPS];
   logic [31:0] ld_mag_ff  [LDIV_STEPS];
   side_type    ld_side_ff [LDIV_STEPS];

   always_ff @(posedge clock) begin
      if (en) begin
         ld_a_ff[0]    <= ldiv_step('{low: pa_ff[29:0], rem: pa_ff[61:30], quo: '0}, mag_ff);
         ld_b_ff[0]    <= ldiv_step('{low: pb_ff[29:0], rem: pb_ff[61:30], quo: '0}, mag_ff);
         ld_mag_ff[0]  <= mag_ff;
         ld_side_ff[0] <= p_side_ff;
      end
   end

   for (genvar s = 1; s < LDIV_STEPS; s++) begin : g_ldiv
      always_ff @(posedge clock) begin
         if (en) begin
            ld_a_ff[s]    <= ldiv_step(ld_a_ff[s-1], ld_mag_ff[s-1]);
            ld_b_ff[s]    <= ldiv_step(ld_b_ff[s-1], ld_mag_ff[s-1]);
            ld_mag_ff[s]  <= ld_mag_ff[s-1];
            ld_side_ff[s] <= ld_side_ff[s-1];
         end
      end
   end

   // ---------------- pick scaled or original vector
   side_type           ld_last;
   logic signed [32:0] alpha_l_ff, beta_l_ff;
   tail_type           l_tail_ff;

   assign ld_last = ld_side_ff[LDIV_STEPS-1];

   always_ff @(posedge clock) begin
      if (en) begin
         alpha_l_ff <= ld_last.limit ?
                       apply_sign(ld_a_ff[LDIV_STEPS-1].quo, ld_last.alpha[32]) : ld_last.alpha;
         beta_l_ff  <= ld_last.limit ?
                       apply_sign(ld_b_ff[LDIV_STEPS-1].quo, ld_last.beta[32]) : ld_last.beta;
         l_tail_ff  <= '{bus: ld_last.bus, limit: ld_last.limit, fault: ld_last.fault,
                         neg: '0, big: '0};
      end
   end

   // ---------------- phase voltages, 2^-30 V units
   logic signed [47:0] bt_ff;
   logic signed [32:0] alpha_v1_ff;
   tail_type           v1_tail_ff;
   logic signed [47:0] ah;
   logic signed [47:0] v_ff [LANES];
   tail_type           v2_tail_ff;

   assign ah = 48'(alpha_v1_ff) <<< 14;

   always_ff @(posedge clock) begin
      if (en) begin
         bt_ff       <= 48'(beta_l_ff) * 48'(HALF_SQRT3_Q15);
         alpha_v1_ff <= alpha_l_ff;
         v1_tail_ff  <= l_tail_ff;

         v_ff[0]    <= 48'(alpha_v1_ff) <<< 15;
         v_ff[1]    <= bt_ff - ah;
         v_ff[2]    <= -ah - bt_ff;
         v2_tail_ff <= v1_tail_ff;
      end
   end

   // ---------------- max and min
   logic signed [47:0] mv_ff [LANES];
   logic signed [47:0] hi_ff, lo_ff;
   logic signed [47:0] hi_ab, lo_ab;
   tail_type           m_tail_ff;

   assign hi_ab = (v_ff[0] > v_ff[1]) ? v_ff[0] : v_ff[1];
   assign lo_ab = (v_ff[0] < v_ff[1]) ? v_ff[0] : v_ff[1];

   always_ff @(posedge clock) begin
      if (en) begin
         mv_ff     <= v_ff;
         hi_ff     <= (hi_ab > v_ff[2]) ? hi_ab : v_ff[2];
         lo_ff     <= (lo_ab < v_ff[2]) ? lo_ab : v_ff[2];
         m_tail_ff <= v2_tail_ff;
      end
   end

   // ---------------- offset removal; fold half duty and rounding, drop 2^17
   logic signed [52:0] bias;
   logic signed [52:0] acc [LANES];
   logic signed [35:0] nn_ff [LANES];
   tail_type           x_tail_ff;

   assign bias = $signed({7'b0, m_tail_ff.bus, 31'b0}) + $signed({22'b0, m_tail_ff.bus, 16'b0});

   for (genvar i = 0; i < LANES; i++) begin : g_x
      assign acc[i] = (53'(mv_ff[i]) <<< 2) - (53'(hi_ff) <<< 1) - (53'(lo_ff) <<< 1) + bias;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < LANES; i++) begin
            nn_ff[i] <= 36'(acc[i] >>> 17);
         end
         x_tail_ff <= m_tail_ff;
      end
   end

   // ---------------- saturation classes and divider load
   ddiv_type kk_ff [LANES];
   tail_type k_tail_ff;
   tail_type k_tail;

   always_comb begin
      k_tail = x_tail_ff;
      for (int i = 0; i < LANES; i++) begin
         k_tail.neg[i] = nn_ff[i][35];
         k_tail.big[i] = !nn_ff[i][35] && (nn_ff[i][34:0] >= {5'b0, x_tail_ff.bus, 15'b0});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < LANES; i++) begin
            kk_ff[i] <= '{low: nn_ff[i][14:0], rem: nn_ff[i][29:15], quo: '0};
         end
         k_tail_ff <= k_tail;
      end
   end

   // ---------------- duty divide by bus
   ddiv_type dd_ff      [DDIV_STEPS][LANES];
   tail_type dd_tail_ff [DDIV_STEPS];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < LANES; i++) begin
            dd_ff[0][i] <= ddiv_step(kk_ff[i], k_tail_ff.bus);
         end
         dd_tail_ff[0] <= k_tail_ff;
      end
   end

   for (genvar s = 1; s < DDIV_STEPS; s++) begin : g_ddiv
      always_ff @(posedge clock) begin
         if (en) begin
            for (int i = 0; i < LANES; i++) begin
               dd_ff[s][i] <= ddiv_step(dd_ff[s-1][i], dd_tail_ff[s-1].bus);
            end
            dd_tail_ff[s] <= dd_tail_ff[s-1];
         end
      end
   end

   // ---------------- select, clamp, result register
   tail_type    c_tail;
   logic [15:0] duty_raw [LANES];
   logic [15:0] duty_cl  [LANES];
   rsp_type     out_ff;

   assign c_tail = dd_tail_ff[DDIV_STEPS-1];

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         if (c_tail.fault) begin
            duty_raw[i] = HALF_DUTY;
         end else if (c_tail.neg[i]) begin
            duty_raw[i] = '0;
         end else if (c_tail.big[i]) begin
            duty_raw[i] = FULL_DUTY;
         end else begin
            duty_raw[i] = {1'b0, dd_ff[DDIV_STEPS-1][i].quo};
         end
         duty_cl[i] = clamp_duty(duty_raw[i], duty_floor, duty_ceiling);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= '{duty_phase_a: duty_cl[0], duty_phase_b: duty_cl[1],
                     duty_phase_c: duty_cl[2], vector_limited: c_tail.limit,
                     bus_fault: c_tail.fault};
      end
   end

   assign out_item = out_ff;

endmodule

`default_nettype wire

### design/foc_voltage_to_svpwm_duty.sv
// Top level: dq voltage command to three SVPWM phase duties (inverse Park, min-max offset).
// Depends on fvsd_pkg, fvsd_front, fvsd_queue and fvsd_back.
//
//  channel | ports                                      | request moves when
//  --------+--------------------------------------------+-----------------------------
//  req     | req_push, req_full, req_data               | req_push & !req_full
//  rsp     | rsp_pop, rsp_empty, rsp_data               | rsp_pop & !rsp_empty
//  csr     | csr_valid, csr_ready, csr_index, csr_wdata | csr_valid & csr_ready
//
// One request per clock sustained while req_full stays low; a result passes through the
// 4 front stages, the middle queue, 85 back stages and the output queue before rsp_data,
// with a 32-step square root, a 30-step scaling divider and a 15-step duty divider.
// Synchronous active-high reset empties both queues and all pipeline valids; floor is 0,
// ceiling is 32768 after reset. csr_ready is always high.
// Front and back stall independently: a full output queue holds the back pipeline, and the
// middle queue absorbs the front's in-flight requests before req_full rises.
`default_nettype none

module foc_voltage_to_svpwm_duty
   import fvsd_pkg::*;
#(
   parameter int unsigned MID_DEPTH = MID_DEPTH_DEF,
   parameter int unsigned RSP_DEPTH = RSP_DEPTH_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   // request side
   input  wire                    req_push,
   output logic                   req_full,
   input  req_type                req_data,
   // result side
   input  wire                    rsp_pop,
   output logic                   rsp_empty,
   output rsp_type                rsp_data,
   // register writes
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire [CSR_INDEX_W-1:0]  csr_index,
   input  wire [15:0]             csr_wdata
);

   localparam int unsigned ITEM_W = $bits(front_item_type);
   localparam int unsigned RSP_W  = $bits(rsp_type);

   // config registers; the user is to have them written only while idle; the block does not enforce it
   logic [15:0] floor_ff, ceil_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= '0;
         ceil_ff  <= FULL_DUTY;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DUTY_FLOOR:   floor_ff <= csr_wdata;
            CSR_DUTY_CEILING: ceil_ff  <= csr_wdata;
            default:          ;   // unknown index ignored
         endcase
      end
   end

   // front: rotation, squares, limit/fault classification
   logic           front_push, mid_full;
   front_item_type front_item;

   fvsd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_push  (req_push),
      .in_req   (req_data),
      .in_full  (req_full),
      .out_full (mid_full),
      .out_push (front_push),
      .out_item (front_item)
   );

   // decoupling queue between front and back
   logic              mid_pop, mid_empty;
   logic [ITEM_W-1:0] mid_rdata;

   fvsd_queue #(.DEPTH(MID_DEPTH), .WIDTH(ITEM_W)) u_mid_queue (
      .clock (clock),
      .reset (reset),
      .push  (front_push),
      .wdata (front_item),
      .full  (mid_full),
      .pop   (mid_pop),
      .rdata (mid_rdata),
      .empty (mid_empty)
   );

   // back: sqrt, scaling, phase voltages, duty divide, clamp
   logic    back_valid, rsp_full;
   rsp_type back_item;
   logic [RSP_W-1:0] rsp_rdata;

   fvsd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .in_empty     (mid_empty),
      .in_item      (front_item_type'(mid_rdata)),
      .in_pop       (mid_pop),
      .duty_floor   (floor_ff),
      .duty_ceiling (ceil_ff),
      .out_full     (rsp_full),
      .out_valid    (back_valid),
      .out_item     (back_item)
   );

   // output queue parts the back end from the consumer
   fvsd_queue #(.DEPTH(RSP_DEPTH), .WIDTH(RSP_W)) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (back_valid),
      .wdata (back_item),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .rdata (rsp_rdata),
      .empty (rsp_empty)
   );

   assign rsp_data = rsp_type'(rsp_rdata);

   // a zero bus never also reports a limited vector
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> !(rsp_data.bus_fault && rsp_data.vector_limited))
      else $error("fault and limit flags both set");

   // duties never exceed full scale
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.duty_phase_a <= FULL_DUTY) &&
                     (rsp_data.duty_phase_b <= FULL_DUTY) &&
                     (rsp_data.duty_phase_c <= FULL_DUTY))
      else $error("duty above full scale");

   // back end only draws from a non-empty middle queue
   assert property (@(posedge clock) disable iff (reset) mid_pop |-> !mid_empty)
      else $error("pop from empty middle queue");

endmodule

`default_nettype wire
